FILE: design/twr_pkg.sv
// Shared types and constants for the ranging responder frame engine.
// Depends on nothing; every other design file refers to it by scoped names.
package twr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SPACE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANT_DELAY  = 3'd4;

  localparam logic [7:0]  RST_ANCHOR_ID  = 8'd1;
  localparam logic [15:0] RST_BASE_DELAY = 16'd800;
  localparam logic [15:0] RST_SLOT_SPACE = 16'd500;
  localparam logic [15:0] RST_GUARD      = 16'd100;
  localparam logic [15:0] RST_ANT_DELAY  = 16'd16436;

  localparam logic [1:0] ACT_RX_BYTE   = 2'd0;
  localparam logic [1:0] ACT_FRAME_END = 2'd1;
  localparam logic [1:0] ACT_TX_DONE   = 2'd2;

  localparam int HDR_LEN     = 10;
  localparam int STORE_LEN   = 11;
  localparam int STORE_IDX_W = 4;
  localparam int TARGET_POS  = 10;
  localparam int SEQ_POS     = 2;
  localparam int PTS_POS     = 10;
  localparam int RTS_POS     = 14;
  localparam int ANCHOR_POS  = 18;
  localparam int RESP_LEN    = 21;

  localparam logic [7:0] POLL_HDR [HDR_LEN] = '{
    8'h41, 8'h88, 8'h00, 8'hCA, 8'hDE, 8'h57, 8'h41, 8'h56, 8'h45, 8'hE0
  };
  localparam logic [7:0] RESP_HDR [HDR_LEN] = '{
    8'h41, 8'h88, 8'h00, 8'hCA, 8'hDE, 8'h56, 8'h45, 8'h57, 8'h41, 8'hE1
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic [39:0] rx_timestamp;
    logic        frame_good;
    logic        tx_ok;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [4:0]  byte_index;
    logic [31:0] delayed_tx_time;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [15:0] reply_base_uus;
    logic [15:0] slot_step_uus;
    logic [15:0] guard_uus;
    logic [15:0] tx_antenna_delay;
  } cfg_t;

  typedef struct packed {
    logic        is_reset;
    logic [39:0] ts;
    logic [7:0]  seq;
  } job_t;

endpackage

FILE: design/twr_responder_frame_engine.sv
// Top level of the ranging responder frame engine: configuration registers,
// front end, job queue and back end. Uses twr_pkg, twr_front, twr_queue, twr_back.
//
// Usage: the in_ channel carries received bytes, frame-end events (receive
// timestamp and frame check flag) and transmit outcomes, one transfer per cycle while in_ready is high.
// The out_ channel carries the 21 bytes of a response frame, each with its
// scheduled transmit time, or a single receiver-reset request marked last.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while idle, as the block does not enforce it. Throughput: one
// input transfer per cycle while the job queue has room. A response job passes
// the queue and S_MUL, S_SUM, S_RTS; S_SEND then registers one byte per cycle
// while the receiver takes each, and the back end takes no new job until done.
// A stalled receiver holds the output register; the back end waits, the
// QUEUE_DEPTH-entry job queue fills and only then in_ready drops.
// Reset: synchronous, active low; clears counters, sequence number, pending
// flag, queue and output valid, and loads the register defaults.
module twr_responder_frame_engine #(
  parameter int MAX_FRAME_BYTES = 24,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  twr_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output twr_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [twr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [twr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  twr_pkg::cfg_t cfg_r, cfg_nxt;
  logic          q_push, q_full, q_empty, q_pop;
  twr_pkg::job_t q_push_job, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        twr_pkg::CFG_ANCHOR_ID:  cfg_nxt.node_id          = cfg_wdata[7:0];
        twr_pkg::CFG_BASE_DELAY: cfg_nxt.reply_base_uus   = cfg_wdata;
        twr_pkg::CFG_SLOT_SPACE: cfg_nxt.slot_step_uus    = cfg_wdata;
        twr_pkg::CFG_GUARD:      cfg_nxt.guard_uus        = cfg_wdata;
        twr_pkg::CFG_ANT_DELAY:  cfg_nxt.tx_antenna_delay = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id          <= twr_pkg::RST_ANCHOR_ID;
      cfg_r.reply_base_uus   <= twr_pkg::RST_BASE_DELAY;
      cfg_r.slot_step_uus    <= twr_pkg::RST_SLOT_SPACE;
      cfg_r.guard_uus        <= twr_pkg::RST_GUARD;
      cfg_r.tx_antenna_delay <= twr_pkg::RST_ANT_DELAY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  twr_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push_valid(q_push),
    .push_job  (q_push_job)
  );

  twr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  twr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_reset_req_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind) |-> (out_item.last && out_item.byte_index == 5'd0
      && out_item.tx_byte == 8'h00 && out_item.delayed_tx_time == 32'd0))
    else $error("malformed receiver-reset request");

  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.kind) |->
      (out_item.last == (out_item.byte_index == 5'(twr_pkg::RESP_LEN - 1))))
    else $error("last flag does not match final response byte");

endmodule

FILE: design/twr_front.sv
// Front end: accepts input transfers, stores the poll header, classifies frames.
// Pushes response and receiver-reset jobs into the job queue. Uses twr_pkg.
module twr_front #(
  parameter int MAX_FRAME_BYTES = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  twr_pkg::in_item_t in_item,
  input  twr_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              push_valid,
  output twr_pkg::job_t     push_job
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(twr_pkg::STORE_LEN);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_FRAME_BYTES);

  logic [7:0]       hdr_r [twr_pkg::STORE_LEN];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic             pend_r, pend_nxt;
  logic             hdr_we;
  logic             accept;
  logic             hdr_match;
  logic             len_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len_ok   = (cnt_r >= MIN_LEN) && (cnt_r <= MAX_LEN);

  always_comb begin
    hdr_match = 1'b1;
    for (int i = 0; i < twr_pkg::HDR_LEN; i++) begin
      if (i != twr_pkg::SEQ_POS && hdr_r[i] != twr_pkg::POLL_HDR[i]) begin
        hdr_match = 1'b0;
      end
    end
    if (hdr_r[twr_pkg::TARGET_POS] != 8'd0 && hdr_r[twr_pkg::TARGET_POS] != cfg.node_id) begin
      hdr_match = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt           = cnt_r;
    seq_nxt           = seq_r;
    pend_nxt          = pend_r;
    hdr_we            = 1'b0;
    push_valid        = 1'b0;
    push_job.is_reset = 1'b1;
    push_job.ts       = in_item.rx_timestamp;
    push_job.seq      = seq_r;
    if (accept) begin
      unique case (in_item.action)
        twr_pkg::ACT_RX_BYTE: begin
          hdr_we = (cnt_r < MIN_LEN);
          if (cnt_r < CNT_MAX) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        twr_pkg::ACT_FRAME_END: begin
          cnt_nxt = '0;
          if (!in_item.frame_good) begin
            push_valid = 1'b1;
          end else if (len_ok && hdr_match) begin
            push_valid        = 1'b1;
            push_job.is_reset = 1'b0;
            pend_nxt          = 1'b1;
          end
        end
        twr_pkg::ACT_TX_DONE: begin
          if (pend_r) begin
            pend_nxt = 1'b0;
            if (in_item.tx_ok) begin
              seq_nxt = seq_r + 8'd1;
            end else begin
              push_valid = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[cnt_r[twr_pkg::STORE_IDX_W-1:0]] <= in_item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      seq_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      seq_r  <= seq_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: design/twr_queue.sv
// Short job queue between front end and back end.
// Holds twr_pkg::job_t entries in registers; first in, first out.
module twr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  twr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output twr_pkg::job_t head,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  twr_pkg::job_t    ent_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign head    = ent_r[rd_r];
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/twr_back.sv
// Back end: computes reply timing for a job and sends its result transfers.
// Takes jobs from twr_queue and configuration from the top level. Uses twr_pkg.
module twr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  twr_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  twr_pkg::job_t      q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output twr_pkg::out_item_t out_item
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUM  = 5'b00100,
    S_RTS  = 5'b01000,
    S_SEND = 5'b10000
  } state_t;

  localparam logic [4:0] IDX_LAST = 5'(twr_pkg::RESP_LEN - 1);

  state_t             state_r, state_nxt;
  twr_pkg::job_t      job_r, job_nxt;
  logic [15:0]        prod_r, prod_nxt;
  logic [31:0]        txt_r, txt_nxt;
  logic [31:0]        rts_r, rts_nxt;
  logic [4:0]         idx_r, idx_nxt;
  logic               ov_r, ov_nxt;
  twr_pkg::out_item_t oi_r, oi_nxt;
  logic               out_free;
  logic [15:0]        anchor_m1;
  logic [31:0]        prod_full;
  logic [15:0]        delay;
  logic [39:0]        sum40;
  logic [7:0]         cur_byte;
  logic               is_last;

  function automatic logic [7:0] resp_byte(input logic [4:0] idx, input logic [7:0] seq,
                                           input logic [31:0] pts, input logic [31:0] rts,
                                           input logic [7:0] anchor);
    logic [4:0] off;
    logic [7:0] b;
    off = '0;
    b   = '0;
    if (idx < 5'(twr_pkg::HDR_LEN)) begin
      b = (idx == 5'(twr_pkg::SEQ_POS)) ? seq : twr_pkg::RESP_HDR[idx[3:0]];
    end else if (idx < 5'(twr_pkg::RTS_POS)) begin
      off = idx - 5'(twr_pkg::PTS_POS);
      b   = 8'(pts >> {off[1:0], 3'b000});
    end else if (idx < 5'(twr_pkg::ANCHOR_POS)) begin
      off = idx - 5'(twr_pkg::RTS_POS);
      b   = 8'(rts >> {off[1:0], 3'b000});
    end else if (idx == 5'(twr_pkg::ANCHOR_POS)) begin
      b = anchor;
    end
    return b;
  endfunction

  assign out_free  = !ov_r || out_ready;
  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign anchor_m1 = {8'h00, cfg.node_id} - 16'd1;
  assign prod_full = anchor_m1 * cfg.slot_step_uus;
  assign delay     = cfg.reply_base_uus + prod_r + cfg.guard_uus;
  assign sum40     = job_r.ts + {8'h00, delay, 16'h0000};
  assign cur_byte  = resp_byte(idx_r, job_r.seq, job_r.ts[31:0], rts_r, cfg.node_id);
  assign is_last   = job_r.is_reset || (idx_r == IDX_LAST);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    prod_nxt  = prod_r;
    txt_nxt   = txt_r;
    rts_nxt   = rts_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    oi_nxt    = oi_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          job_nxt   = q_head;
          idx_nxt   = '0;
          state_nxt = q_head.is_reset ? S_SEND : S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = prod_full[15:0];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        txt_nxt   = sum40[39:8];
        state_nxt = S_RTS;
      end
      S_RTS: begin
        rts_nxt   = {txt_r[23:1], 1'b0, 8'h00} + {16'h0000, cfg.tx_antenna_delay};
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          ov_nxt                 = 1'b1;
          oi_nxt.kind            = job_r.is_reset;
          oi_nxt.tx_byte         = job_r.is_reset ? 8'h00 : cur_byte;
          oi_nxt.byte_index      = job_r.is_reset ? 5'd0 : idx_r;
          oi_nxt.delayed_tx_time = job_r.is_reset ? 32'd0 : txt_r;
          oi_nxt.last            = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    prod_r <= prod_nxt;
    txt_r  <= txt_nxt;
    rts_r  <= rts_nxt;
    idx_r  <= idx_nxt;
    oi_r   <= oi_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

endmodule
